// ===== sv/grc_pkg.sv =====
// ---------------------------------------------------------------------------
// grc_pkg: shared types and constants for the grid ray cast scanner
// Fixed-point constants, command format and the CORDIC angle table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package grc_pkg;

    localparam int MAX_CELLS_DEF = 65536;
    localparam int RAY_COUNT_DEF = 32;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    localparam logic [7:0] OCCUPIED = 8'd100;

    localparam logic signed [20:0] PI_Q16      = 21'sd205887;
    localparam logic signed [20:0] TWO_PI_Q16  = 21'sd411775;
    localparam logic signed [20:0] HALF_PI_Q16 = 21'sd102944;
    localparam logic signed [20:0] STEP_Q16    = 21'sd13107;

    localparam int          CORDIC_STEPS = 24;
    localparam logic [4:0]  CORDIC_LAST  = 5'd23;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    // configuration register indexes
    localparam logic [2:0] CFG_WIDTH   = 3'd0;
    localparam logic [2:0] CFG_HEIGHT  = 3'd1;
    localparam logic [2:0] CFG_CELL    = 3'd2;
    localparam logic [2:0] CFG_POSE_X  = 3'd3;
    localparam logic [2:0] CFG_POSE_Y  = 3'd4;
    localparam logic [2:0] CFG_HEADING = 3'd5;

    typedef struct packed {
        logic        scan;
        logic        load_ok;
        logic [15:0] index;
        logic [7:0]  value;
    } t_cmd;

    function automatic logic [31:0] atan_q30(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'd843314857;
            5'd1:    v = 32'd497837829;
            5'd2:    v = 32'd263043837;
            5'd3:    v = 32'd133525159;
            5'd4:    v = 32'd67021687;
            5'd5:    v = 32'd33543516;
            5'd6:    v = 32'd16775851;
            5'd7:    v = 32'd8388437;
            5'd8:    v = 32'd4194283;
            5'd9:    v = 32'd2097149;
            default: v = 32'd1 << (5'd30 - i);
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== sv/grc_in_if.sv =====
// ---------------------------------------------------------------------------
// grc_in_if: input item channel
// Valid/ready channel carrying grid loads and scan requests.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface grc_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] cell_index;
    logic [7:0]  cell_value;

    modport source (output valid, kind, cell_index, cell_value, input ready);
    modport sink   (input valid, kind, cell_index, cell_value, output ready);
endinterface

`default_nettype wire

// ===== sv/grc_out_if.sv =====
// ---------------------------------------------------------------------------
// grc_out_if: ray result channel
// Valid/ready channel carrying one result per cast ray.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface grc_out_if;
    logic               valid;
    logic               ready;
    logic [4:0]         ray_number;
    logic               hit;
    logic signed [31:0] obstacle_x;
    logic signed [31:0] obstacle_y;
    logic               last_ray;

    modport source (output valid, ray_number, hit, obstacle_x, obstacle_y, last_ray,
                    input ready);
    modport sink   (input valid, ray_number, hit, obstacle_x, obstacle_y, last_ray,
                    output ready);
endinterface

`default_nettype wire

// ===== sv/grc_ram.sv =====
// ---------------------------------------------------------------------------
// grc_ram: generic single-write, single-read memory
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== sv/grc_front.sv =====
// ---------------------------------------------------------------------------
// grc_front: input acceptance and command queue
// Classifies items as scans or loads, flags in-range loads and queues them all.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grc_front #(
    parameter int MAX_CELLS = grc_pkg::MAX_CELLS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    grc_in_if.sink             i_in,
    output logic               o_cmd_valid,
    output grc_pkg::t_cmd      o_cmd,
    input  wire logic          i_cmd_pop
);

    grc_pkg::t_cmd           r_q [grc_pkg::QDEPTH];
    logic [grc_pkg::QAW-1:0] r_wr;
    logic [grc_pkg::QAW-1:0] r_rd;
    logic [grc_pkg::QAW:0]   r_cnt;
    logic [grc_pkg::QAW:0]   n_cnt;
    logic                    push;
    logic                    pop;
    grc_pkg::t_cmd           cmd_in;

    assign i_in.ready  = (r_cnt != grc_pkg::QAW'(0) + (grc_pkg::QAW+1)'(grc_pkg::QDEPTH));
    assign push        = i_in.valid && i_in.ready;
    assign o_cmd_valid = (r_cnt != '0);
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rd];

    always_comb begin
        cmd_in.scan    = i_in.kind;
        cmd_in.load_ok = !i_in.kind && (32'(i_in.cell_index) < 32'(MAX_CELLS));
        cmd_in.index   = i_in.cell_index;
        cmd_in.value   = i_in.cell_value;
        n_cnt = r_cnt + (grc_pkg::QAW+1)'(push) - (grc_pkg::QAW+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= cmd_in;
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// ===== sv/grc_back.sv =====
// ---------------------------------------------------------------------------
// grc_back: grid store, ray sequencer and result register
// Executes loads into the grid and casts rays with a shared CORDIC.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grc_back #(
    parameter int MAX_CELLS = grc_pkg::MAX_CELLS_DEF,
    parameter int RAY_COUNT = grc_pkg::RAY_COUNT_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [2:0]    i_cfg_idx,
    input  wire logic [31:0]   i_cfg_data,
    input  wire logic          i_cmd_valid,
    input  wire grc_pkg::t_cmd i_cmd,
    output logic               o_cmd_pop,
    grc_out_if.source          o_out
);

    localparam int AW  = $clog2(MAX_CELLS);
    localparam int RCW = (RAY_COUNT > 1) ? $clog2(RAY_COUNT) : 1;
    localparam logic [RCW-1:0] RAY_LAST = RCW'(RAY_COUNT - 1);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_WRAP   = 11'b00000000010,
        S_CORDIC = 11'b00000000100,
        S_ROUND  = 11'b00000001000,
        S_MUL    = 11'b00000010000,
        S_BOUND  = 11'b00000100000,
        S_ADDR   = 11'b00001000000,
        S_CHECK  = 11'b00010000000,
        S_HMUL   = 11'b00100000000,
        S_HADD   = 11'b01000000000,
        S_EMIT   = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [8:0]         r_width;
    logic [8:0]         r_height;
    logic [31:0]        r_cell;
    logic signed [31:0] r_pose_x;
    logic signed [31:0] r_pose_y;
    logic signed [18:0] r_heading;

    // ray datapath
    logic [RCW-1:0]     r_ray;
    logic signed [20:0] r_ang;
    logic               r_neg;
    logic signed [33:0] r_x, r_y, r_z;
    logic [4:0]         r_i;
    logic signed [17:0] r_cos, r_sin;
    logic [8:0]         r_k;
    logic signed [27:0] r_kc, r_ks;
    logic [8:0]         r_col, r_row;
    logic               r_rd_ok;
    logic signed [60:0] r_px, r_py;
    logic               r_hit;
    logic signed [31:0] r_ox, r_oy;

    // result register
    logic               r_out_valid, n_out_valid;
    logic [4:0]         r_o_ray;
    logic               r_o_hit;
    logic signed [31:0] r_o_x, r_o_y;
    logic               r_o_last;

    logic [7:0]         rdata;
    logic               ram_we;
    logic [31:0]        waddr_w;
    logic [AW-1:0]      raddr_w;
    logic               emit;
    logic signed [20:0] ang_fold;
    logic               fold_neg;
    logic signed [33:0] dx, dy, atan_e;
    logic signed [33:0] xr, yr;
    logic signed [27:0] kc_rnd, ks_rnd;
    logic signed [12:0] col_s, row_s;
    logic               outside;
    logic [18:0]        addr;
    logic signed [45:0] sum_x, sum_y;
    logic [RCW+4:0]     ray_ext;

    grc_ram #(
        .WIDTH (8),
        .DEPTH (MAX_CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (waddr_w[AW-1:0]),
        .i_wdata (i_cmd.value),
        .i_raddr (raddr_w),
        .o_rdata (rdata)
    );

    function automatic logic signed [31:0] sat32(input logic signed [45:0] v);
        logic signed [31:0] s;
        if (v > 46'sd2147483647) begin
            s = 32'sh7fffffff;
        end else if (v < -46'sd2147483648) begin
            s = 32'sh80000000;
        end else begin
            s = v[31:0];
        end
        return s;
    endfunction

    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;
    assign ram_we    = o_cmd_pop && i_cmd.load_ok;
    assign waddr_w   = 32'(i_cmd.index);
    // present the probe address in S_ADDR so the read data is ready in S_CHECK
    assign raddr_w   = AW'(addr);
    assign emit      = (r_state == S_EMIT) && (!r_out_valid || o_out.ready);

    always_comb begin
        // fold into [-pi/2, pi/2]
        if (r_ang > grc_pkg::HALF_PI_Q16) begin
            ang_fold = r_ang - grc_pkg::PI_Q16;
            fold_neg = 1'b1;
        end else if (r_ang < -grc_pkg::HALF_PI_Q16) begin
            ang_fold = r_ang + grc_pkg::PI_Q16;
            fold_neg = 1'b1;
        end else begin
            ang_fold = r_ang;
            fold_neg = 1'b0;
        end
        dx     = r_y >>> r_i;
        dy     = r_x >>> r_i;
        atan_e = $signed({2'b00, grc_pkg::atan_q30(r_i)});
        xr     = (r_x + 34'sd8192) >>> 14;
        yr     = (r_y + 34'sd8192) >>> 14;
        kc_rnd = r_kc + 28'sd32768;
        ks_rnd = r_ks + 28'sd32768;
        col_s  = $signed({kc_rnd[27], kc_rnd[27:16]}) + $signed({5'b0, r_width[8:1]});
        row_s  = $signed({ks_rnd[27], ks_rnd[27:16]}) + $signed({5'b0, r_height[8:1]});
        outside = col_s[12] || row_s[12] ||
                  (col_s[11:0] >= {3'b0, r_width}) || (row_s[11:0] >= {3'b0, r_height});
        addr   = (19'(r_row) * 19'(r_width)) + 19'(r_col);
        sum_x  = 46'(r_pose_x) + 46'((r_px + 61'sd32768) >>> 16);
        sum_y  = 46'(r_pose_y) + 46'((r_py + 61'sd32768) >>> 16);
        ray_ext = (RCW+5)'(r_ray);
        n_out_valid = (r_out_valid && !o_out.ready) || emit;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd_pop && i_cmd.scan) begin
                    n_state = S_WRAP;
                end
            end
            S_WRAP: begin
                if (r_ang <= grc_pkg::PI_Q16 && r_ang >= -grc_pkg::PI_Q16) begin
                    n_state = S_CORDIC;
                end
            end
            S_CORDIC: begin
                if (r_i == grc_pkg::CORDIC_LAST) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: n_state = S_MUL;
            S_MUL:   n_state = S_BOUND;
            S_BOUND: n_state = outside ? S_EMIT : S_ADDR;
            S_ADDR:  n_state = S_CHECK;
            S_CHECK: begin
                if (r_rd_ok && rdata == grc_pkg::OCCUPIED) begin
                    n_state = S_HMUL;
                end else if (r_k == r_width) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_HMUL: n_state = S_HADD;
            S_HADD: n_state = S_EMIT;
            S_EMIT: begin
                if (emit) begin
                    n_state = (r_ray == RAY_LAST) ? S_IDLE : S_WRAP;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_width     <= 9'd256;
            r_height    <= 9'd256;
            r_cell      <= 32'd65536;
            r_pose_x    <= '0;
            r_pose_y    <= '0;
            r_heading   <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    grc_pkg::CFG_WIDTH:   r_width   <= i_cfg_data[8:0];
                    grc_pkg::CFG_HEIGHT:  r_height  <= i_cfg_data[8:0];
                    grc_pkg::CFG_CELL:    r_cell    <= i_cfg_data;
                    grc_pkg::CFG_POSE_X:  r_pose_x  <= i_cfg_data;
                    grc_pkg::CFG_POSE_Y:  r_pose_y  <= i_cfg_data;
                    grc_pkg::CFG_HEADING: r_heading <= i_cfg_data[18:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_ray <= '0;
                r_ang <= 21'(r_heading) - grc_pkg::PI_Q16;
            end
            S_WRAP: begin
                if (r_ang > grc_pkg::PI_Q16) begin
                    r_ang <= r_ang - grc_pkg::TWO_PI_Q16;
                end else if (r_ang < -grc_pkg::PI_Q16) begin
                    r_ang <= r_ang + grc_pkg::TWO_PI_Q16;
                end else begin
                    r_neg <= fold_neg;
                    r_z   <= 34'(ang_fold) <<< 14;
                    r_x   <= grc_pkg::CORDIC_GAIN;
                    r_y   <= '0;
                    r_i   <= '0;
                end
            end
            S_CORDIC: begin
                if (!r_z[33]) begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - atan_e;
                end else begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + atan_e;
                end
                r_i <= r_i + 1'b1;
            end
            S_ROUND: begin
                r_cos <= r_neg ? -xr[17:0] : xr[17:0];
                r_sin <= r_neg ? -yr[17:0] : yr[17:0];
                r_k   <= '0;
            end
            S_MUL: begin
                r_kc <= $signed({1'b0, r_k}) * r_cos;
                r_ks <= $signed({1'b0, r_k}) * r_sin;
            end
            S_BOUND: begin
                r_col <= col_s[8:0];
                r_row <= row_s[8:0];
                r_hit <= 1'b0;
                r_ox  <= '0;
                r_oy  <= '0;
            end
            S_ADDR: begin
                r_rd_ok <= (32'(addr) < 32'(MAX_CELLS));
            end
            S_CHECK: begin
                r_k <= r_k + 1'b1;
            end
            S_HMUL: begin
                r_px <= r_kc * $signed({1'b0, r_cell});
                r_py <= r_ks * $signed({1'b0, r_cell});
            end
            S_HADD: begin
                r_hit <= 1'b1;
                r_ox  <= sat32(sum_x);
                r_oy  <= sat32(sum_y);
            end
            S_EMIT: begin
                if (emit) begin
                    r_o_ray  <= ray_ext[4:0];
                    r_o_hit  <= r_hit;
                    r_o_x    <= r_ox;
                    r_o_y    <= r_oy;
                    r_o_last <= (r_ray == RAY_LAST);
                    r_ray    <= r_ray + 1'b1;
                    r_ang    <= r_ang + grc_pkg::STEP_Q16;
                end
            end
            default: ;
        endcase
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.ray_number = r_o_ray;
    assign o_out.hit        = r_o_hit;
    assign o_out.obstacle_x = r_o_x;
    assign o_out.obstacle_y = r_o_y;
    assign o_out.last_ray   = r_o_last;

endmodule

`default_nettype wire

// ===== sv/grid_ray_cast_obstacle_scan_top.sv =====
// Loads: one per cycle while the back end is idle; a load is written to the grid at the
//   edge after its transfer, or waits in the 4-entry queue while a scan runs.
// Scan: per ray an angle wrap (repeated per 2*pi fold), 24-step CORDIC and rounding,
//   then per probed cell multiply, bound check, address, read (a step leaving the grid
//   stops after bound check), on a hit multiply and add, and emit (held while full).
// Reset clears control and sets configuration to its reset values; grid contents
//   stay undefined until loaded. No clearing pass.
// ---------------------------------------------------------------------------
// grid_ray_cast_obstacle_scan_top: occupancy grid ray scanner
// Queues grid loads and scans, casts rays and returns one result per ray.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grid_ray_cast_obstacle_scan_top #(
    parameter int MAX_CELLS = grc_pkg::MAX_CELLS_DEF,
    parameter int RAY_COUNT = grc_pkg::RAY_COUNT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    grc_in_if.sink           i_in,
    grc_out_if.source        o_out
);

    logic          cmd_valid;
    logic          cmd_pop;
    grc_pkg::t_cmd cmd;

    grc_front #(
        .MAX_CELLS (MAX_CELLS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    grc_back #(
        .MAX_CELLS (MAX_CELLS),
        .RAY_COUNT (RAY_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

// ===== tb/sv/tb_grid_ray_cast_obstacle_scan_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_grid_ray_cast_obstacle_scan_top: self-checking bench for the ray scanner
// Loads grid cells and starts scans under several register settings and
// handshake idle patterns. A scoreboard mirrors the grid and predicts the
// 32 ray results of each scan, which are checked field by field.
// ---------------------------------------------------------------------------

class RayScoreboard;
    typedef struct {
        logic [4:0]         ray;
        logic               hit;
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic               last;
    } t_ray_result;

    t_ray_result       pending_rays[$];
    logic [7:0]        grid[0:65535];
    bit                known[0:65535];
    logic [8:0]        width_r;
    logic [8:0]        height_r;
    logic [31:0]       cell_r;
    longint            pose_x_r;
    longint            pose_y_r;
    longint            heading_r;
    int                errors;
    int                scans;
    int                results;
    int                hits;
    int                occupied_pct;
    int                fill_idx[$];
    logic [7:0]        fill_val[$];

    function new();
        errors = 0; scans = 0; results = 0; hits = 0; occupied_pct = 30;
        width_r = 256; height_r = 256; cell_r = 32'd65536;
        pose_x_r = 0; pose_y_r = 0; heading_r = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] v);
        case (idx)
            grc_pkg::CFG_WIDTH:   width_r = v[8:0];
            grc_pkg::CFG_HEIGHT:  height_r = v[8:0];
            grc_pkg::CFG_CELL:    cell_r = v;
            grc_pkg::CFG_POSE_X:  pose_x_r = longint'($signed(v));
            grc_pkg::CFG_POSE_Y:  pose_y_r = longint'($signed(v));
            grc_pkg::CFG_HEADING: heading_r = longint'($signed(v[18:0]));
            default: ;
        endcase
    endfunction

    function void sin_cos(longint ang, output longint s, output longint c);
        longint atan_tab[24] = '{843314857, 497837829, 263043837, 133525159, 67021687,
            33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
            131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};
        longint x, y, z, dx, dy;
        bit flip;
        flip = 0;
        while (ang > 205887) ang -= 411775;
        while (ang < -205887) ang += 411775;
        if (ang > 102944) begin
            ang -= 205887; flip = 1;
        end else if (ang < -102944) begin
            ang += 205887; flip = 1;
        end
        x = 652032874; y = 0; z = ang * 16384;
        for (int i = 0; i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_tab[i];
            end else begin
                x += dx; y -= dy; z += atan_tab[i];
            end
        end
        x = (x + 8192) >>> 14;
        y = (y + 8192) >>> 14;
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Walk one ray. In planning mode, unwritten cells on the path get a value
    // now and are queued as loads so the scan never reads an unloaded cell.
    function t_ray_result cast_ray(int r, bit plan);
        t_ray_result res;
        longint s, c, col, row, addr, hit_span;
        logic [7:0] v;
        res = '{ray: r[4:0], hit: 0, ox: 0, oy: 0, last: (r == 31)};
        sin_cos(heading_r - 205887 + 13107 * r, s, c);
        for (longint k = 0; k <= longint'(width_r); k++) begin
            col = ((k * c + 32768) >>> 16) + longint'(width_r / 2);
            row = ((k * s + 32768) >>> 16) + longint'(height_r / 2);
            if (col < 0 || col >= width_r || row < 0 || row >= height_r) break;
            addr = row * width_r + col;
            v = 0;
            if (addr < 65536) begin
                if (plan && !known[addr]) begin
                    grid[addr] = ($urandom_range(99) < occupied_pct) ? grc_pkg::OCCUPIED
                                                                     : 8'($urandom);
                    known[addr] = 1;
                    fill_idx = {fill_idx, int'(addr)};
                    fill_val = {fill_val, grid[addr]};
                end
                v = grid[addr];
            end
            if (v == grc_pkg::OCCUPIED) begin
                hit_span = k * longint'(cell_r);
                res.hit = 1;
                res.ox = 32'(sat32(pose_x_r + ((hit_span * c + 32768) >>> 16)));
                res.oy = 32'(sat32(pose_y_r + ((hit_span * s + 32768) >>> 16)));
                break;
            end
        end
        return res;
    endfunction

    function void plan_fill();
        t_ray_result unused;
        fill_idx.delete();
        fill_val.delete();
        for (int r = 0; r < 32; r++) unused = cast_ray(r, 1);
    endfunction

    function void note_input(logic kind, logic [15:0] idx, logic [7:0] v);
        if (!kind) begin
            grid[idx] = v;
            known[idx] = 1;
            return;
        end
        scans++;
        for (int r = 0; r < 32; r++) pending_rays = {pending_rays, cast_ray(r, 0)};
    endfunction

    function void check_result(logic [4:0] ray, logic hit, logic signed [31:0] ox,
                               logic signed [31:0] oy, logic last);
        t_ray_result e;
        if (pending_rays.size() == 0) begin
            $error("ray result with no scan pending: ray %0d", ray);
            errors++;
            return;
        end
        e = pending_rays.pop_front();
        results++;
        if (hit) hits++;
        if (ray !== e.ray) begin
            $error("ray_number exp %0d got %0d", e.ray, ray); errors++;
        end
        if (hit !== e.hit) begin
            $error("hit exp %0d got %0d (ray %0d)", e.hit, hit, e.ray); errors++;
        end
        if (ox !== e.ox) begin
            $error("obstacle_x exp %0d got %0d (ray %0d)", e.ox, ox, e.ray); errors++;
        end
        if (oy !== e.oy) begin
            $error("obstacle_y exp %0d got %0d (ray %0d)", e.oy, oy, e.ray); errors++;
        end
        if (last !== e.last) begin
            $error("last_ray exp %0d got %0d (ray %0d)", e.last, last, e.ray); errors++;
        end
    endfunction
endclass

module tb_grid_ray_cast_obstacle_scan_top;

    localparam longint CYCLE_LIMIT = 4000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    grc_in_if  in_if();
    grc_out_if out_if();

    grid_ray_cast_obstacle_scan_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    RayScoreboard sb;
    int     src_idle_pct;
    int     sink_stall_pct;
    bit     hold_req;
    bit     hold_taken;
    int     hold_left;
    longint cycles;
    int     items_sent;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: check each transfer, then pick the next ready level.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            hold_left <= 0;
            hold_taken <= 0;
        end else begin
            if (out_if.valid && out_if.ready)
                sb.check_result(out_if.ray_number, out_if.hit, out_if.obstacle_x,
                                out_if.obstacle_y, out_if.last_ray);
            if (hold_req && !hold_taken) begin
                hold_taken <= 1;
                hold_left <= 3000;
                out_if.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    task automatic send_item(input logic kind, input logic [15:0] idx, input logic [7:0] v);
        int gap;
        gap = 0;
        while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct && gap < 16) gap++;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.kind       <= kind;
        in_if.cell_index <= idx;
        in_if.cell_value <= v;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sb.note_input(kind, idx, v);
        items_sent++;
    endtask

    // Load every not yet loaded cell the coming scan will probe, then start the scan.
    task automatic run_scan();
        sb.plan_fill();
        foreach (sb.fill_idx[i]) send_item(1'b0, 16'(sb.fill_idx[i]), sb.fill_val[i]);
        send_item(1'b1, 16'($urandom), 8'($urandom));
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        while (sb.pending_rays.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [31:0] vals[6], input bit junk);
        for (int i = 0; i < 6; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= 3'(i);
            i_cfg_data <= vals[i];
            sb.set_reg(3'(i), vals[i]);
            @(posedge i_clk);
        end
        if (junk) begin
            // indexes past the register list are ignored
            i_cfg_idx  <= 3'd6;
            i_cfg_data <= $urandom;
            @(posedge i_clk);
            i_cfg_idx  <= 3'd7;
            i_cfg_data <= $urandom;
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_idling(input int mode);
        case (mode % 4)
            0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_idle_pct = 60; sink_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct = 60; end
            default: begin src_idle_pct = 26; sink_stall_pct = 26; end
        endcase
    endtask

    task automatic random_traffic(input int n);
        int area;
        for (int i = 0; i < n; i++) begin
            area = int'(sb.width_r) * int'(sb.height_r);
            if ($urandom_range(9) == 0) run_scan();
            else if ($urandom_range(3) == 0 || area == 0)
                send_item(1'b0, 16'($urandom), 8'($urandom));
            else
                send_item(1'b0, 16'($urandom_range((area > 65536 ? 65536 : area) - 1)),
                          ($urandom_range(2) == 0) ? grc_pkg::OCCUPIED : 8'($urandom));
        end
    endtask

    initial begin
        logic [31:0] regs[6];
        sb = new();
        cycles = 0;
        items_sent = 0;
        hold_req = 0;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_if.valid = 1'b0;
        in_if.kind = 1'b0;
        in_if.cell_index = '0;
        in_if.cell_value = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: full 256 x 256 grid, plus extreme load fields
        sb.occupied_pct = 40;
        send_item(1'b0, 16'd0, 8'd0);
        send_item(1'b0, 16'hFFFF, 8'hFF);
        send_item(1'b0, 16'h5A5A, grc_pkg::OCCUPIED);
        run_scan();
        drain();

        // single cell, saturating pose, heading at +pi
        set_idling(1);
        regs = '{32'd1, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'd205887};
        write_regs(regs, 1);
        send_item(1'b0, 16'd0, grc_pkg::OCCUPIED);
        run_scan();
        send_item(1'b0, 16'd0, 8'd99);
        run_scan();
        drain();

        // zero width: rays leave the grid at once
        set_idling(2);
        regs = '{32'd0, 32'd5, 32'd1, 32'd0, 32'd0, 32'h7_CBB1};
        write_regs(regs, 0);
        run_scan();
        drain();

        // one row of 256, largest cell size, heading past +pi
        set_idling(3);
        regs = '{32'd256, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_0000, 32'hFFFF_0000, 32'h3_FFFF};
        write_regs(regs, 0);
        run_scan();
        drain();

        // one column of 256, heading past -pi
        set_idling(0);
        regs = '{32'd1, 32'd256, 32'd65536, 32'hC000_0000, 32'h4000_0000, 32'h4_0000};
        write_regs(regs, 0);
        run_scan();
        drain();

        // oversized grid: far cells sit past the store and read as empty
        sb.occupied_pct = 30;
        regs = '{32'd300, 32'd300, 32'd3000, 32'd12345, -32'd54321, 32'h0_1234};
        write_regs(regs, 0);
        run_scan();
        drain();

        // random small grids across the idle patterns
        sb.occupied_pct = 20;
        for (int p = 0; p < 8; p++) begin
            set_idling(p);
            regs[0] = $urandom_range(24, 2);
            regs[1] = $urandom_range(24, 1);
            regs[2] = $urandom;
            regs[3] = $urandom;
            regs[4] = $urandom;
            regs[5] = $urandom_range(19'h7FFFF);
            write_regs(regs, p == 3);
            if (p == 5) begin
                // long result back-pressure while scans keep arriving
                hold_req = 1;
                run_scan();
                run_scan();
                run_scan();
                random_traffic(6);
            end
            random_traffic(8);
            run_scan();
            drain();
        end

        $display("ran %0d input transfers, %0d scans, %0d ray results (%0d hits)",
                 items_sent, sb.scans, sb.results, sb.hits);
        $display("covered reset, extreme and random grid settings under four idle patterns");
        if (sb.errors == 0 && sb.pending_rays.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.errors,
                     sb.pending_rays.size());
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
